// File: design/pci_pkg.sv
// Shared constants, register codes and width helpers for the pulse charge integrator.
`default_nettype none

package pci_pkg;

   localparam int EXPLEN_W   = 17;
   localparam int CFG_W      = 16;
   localparam int CNT_W      = 17;
   localparam int AREA_W     = 42;
   localparam int LEVEL_W    = 26;
   localparam int CSR_ADDR_W = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_EXPECTED_LENGTH = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BASELINE_LAST   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_START    = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_END      = 2'd3;

   localparam logic [EXPLEN_W-1:0] EXPECTED_LENGTH_RST = 17'd10000;
   localparam logic [CFG_W-1:0]    BASELINE_LAST_RST   = 16'd1000;
   localparam logic [CFG_W-1:0]    WINDOW_START_RST    = 16'd3000;
   localparam logic [CFG_W-1:0]    WINDOW_END_RST      = 16'd4000;

   // baseline sum covers up to 2^CFG_W samples
   function automatic int bs_width(input int sample_bits);
      return sample_bits + CFG_W + 1;
   endfunction

   function automatic int ws_width(input int sample_bits);
      return sample_bits + CNT_W;
   endfunction

   // event record: bsum, wsum, min, max, count, baseline_last, empty, length error
   function automatic int rec_width(input int sample_bits);
      return bs_width(sample_bits) + ws_width(sample_bits) + 2 * sample_bits
             + CNT_W + CFG_W + 2;
   endfunction

endpackage

`default_nettype wire

// File: design/pci_if.sv
// Handshake channel interfaces: sample input, result output and register writes.
`default_nettype none

interface pci_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface pci_rsp_if;
   import pci_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [AREA_W-1:0]  area;
   logic signed [LEVEL_W-1:0] min_level;
   logic signed [LEVEL_W-1:0] max_level;
   logic                      length_error;
   logic                      window_empty;

   modport source (output valid, output area, output min_level, output max_level,
                   output length_error, output window_empty, input ready);
   modport sink   (input valid, input area, input min_level, input max_level,
                   input length_error, input window_empty, output ready);
endinterface

interface pci_csr_if;
   import pci_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [EXPLEN_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/pulse_charge_integrator.sv
// A finished event's record waits in the record queue; the back end then runs the
// one-bit-per-cycle baseline divider, forms the mean and product, and registers the result.
// Throughput: one sample per cycle while the record queue has room. The back end finishes
// one event at a time, waiting on a stalled result sink; QUEUE_DEPTH events can wait.
// Reset: synchronous, clears event state and loads the register defaults
// (expected_length 10000, baseline_last 1000, window 3000 to 4000).
`default_nettype none

module pulse_charge_integrator #(
   parameter int SAMPLE_BITS   = 16,
   parameter int MAX_LENGTH    = 65536,
   parameter int FRACTION_BITS = 8,
   parameter int QUEUE_DEPTH   = 2
) (
   input  wire logic clock,
   input  wire logic reset,
   pci_req_if.sink   req_bus,
   pci_rsp_if.source rsp_bus,
   pci_csr_if.sink   csr_bus
);
   import pci_pkg::*;

   localparam int REC_W = rec_width(SAMPLE_BITS);

   logic             q_full;
   logic             q_empty;
   logic             q_push;
   logic             q_pop;
   logic [REC_W-1:0] rec_in;
   logic [REC_W-1:0] rec_out;

   pci_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_LENGTH  (MAX_LENGTH)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .csr    (csr_bus),
      .q_full (q_full),
      .push   (q_push),
      .rec    (rec_in)
   );

   pci_queue #(
      .WIDTH (REC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (rec_in),
      .pop       (q_pop),
      .pop_data  (rec_out),
      .full      (q_full),
      .empty     (q_empty)
   );

   pci_back #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (rec_out),
      .q_pop   (q_pop),
      .rsp     (rsp_bus)
   );

endmodule

`default_nettype wire

// File: design/pci_front.sv
// Front end: configuration registers, per-sample classification and event accumulation.
`default_nettype none

module pci_front #(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_LENGTH  = 65536
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   pci_req_if.sink                                          req,
   pci_csr_if.sink                                          csr,
   input  wire logic                                        q_full,
   output logic                                             push,
   output logic [pci_pkg::rec_width(SAMPLE_BITS)-1:0]       rec
);
   import pci_pkg::*;

   localparam int IDX_W = $clog2(2 * MAX_LENGTH);
   localparam int CMP_W = (IDX_W > EXPLEN_W) ? IDX_W : EXPLEN_W;
   localparam int BS_W  = bs_width(SAMPLE_BITS);
   localparam int WS_W  = ws_width(SAMPLE_BITS);
   localparam logic [IDX_W-1:0] INDEX_MAX = IDX_W'(2 * MAX_LENGTH - 1);
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic [EXPLEN_W-1:0] expected_length_ff;
   logic [CFG_W-1:0]    baseline_last_ff;
   logic [CFG_W-1:0]    window_start_ff;
   logic [CFG_W-1:0]    window_end_ff;

   logic [IDX_W-1:0]              sample_index_ff, sample_index_in;
   logic signed [BS_W-1:0]        baseline_sum_ff, baseline_sum_in;
   logic signed [WS_W-1:0]        window_sum_ff, window_sum_in;
   logic [CNT_W-1:0]              window_count_ff, window_count_in;
   logic signed [SAMPLE_BITS-1:0] window_min_ff, window_min_in;
   logic signed [SAMPLE_BITS-1:0] window_max_ff, window_max_in;

   logic accept;
   logic in_base;
   logic in_window;
   logic length_error;
   logic window_empty;

   assign csr.ready = 1'b1;
   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      in_base   = CMP_W'(sample_index_ff) <= CMP_W'(baseline_last_ff);
      // window samples begin only after the baseline ends, never at the saturated index
      in_window = !in_base
                  && CMP_W'(sample_index_ff) >= CMP_W'(window_start_ff)
                  && CMP_W'(sample_index_ff) <= CMP_W'(window_end_ff)
                  && sample_index_ff != INDEX_MAX;

      sample_index_in = (sample_index_ff != INDEX_MAX) ? sample_index_ff + 1'b1
                                                       : sample_index_ff;
      baseline_sum_in = in_base ? baseline_sum_ff + BS_W'(req.sample) : baseline_sum_ff;
      window_sum_in   = in_window ? window_sum_ff + WS_W'(req.sample) : window_sum_ff;
      window_count_in = in_window ? window_count_ff + 1'b1 : window_count_ff;
      window_min_in   = (in_window && req.sample < window_min_ff) ? req.sample
                                                                 : window_min_ff;
      window_max_in   = (in_window && req.sample > window_max_ff) ? req.sample
                                                                 : window_max_ff;

      length_error = CMP_W'(sample_index_in) != CMP_W'(expected_length_ff);
      window_empty = window_count_in == '0;
   end

   assign push = accept && req.last_sample;
   assign rec  = {length_error, window_empty, baseline_last_ff, window_count_in,
                  window_max_in, window_min_in, window_sum_in, baseline_sum_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_length_ff <= EXPECTED_LENGTH_RST;
         baseline_last_ff   <= BASELINE_LAST_RST;
         window_start_ff    <= WINDOW_START_RST;
         window_end_ff      <= WINDOW_END_RST;
         sample_index_ff    <= '0;
         baseline_sum_ff    <= '0;
         window_sum_ff      <= '0;
         window_count_ff    <= '0;
         window_min_ff      <= SAMPLE_MAX;
         window_max_ff      <= SAMPLE_MIN;
      end else begin
         if (csr.valid) begin
            case (csr.index)
               CSR_EXPECTED_LENGTH: expected_length_ff <= csr.data;
               CSR_BASELINE_LAST:   baseline_last_ff   <= csr.data[CFG_W-1:0];
               CSR_WINDOW_START:    window_start_ff    <= csr.data[CFG_W-1:0];
               CSR_WINDOW_END:      window_end_ff      <= csr.data[CFG_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            if (req.last_sample) begin
               sample_index_ff <= '0;
               baseline_sum_ff <= '0;
               window_sum_ff   <= '0;
               window_count_ff <= '0;
               window_min_ff   <= SAMPLE_MAX;
               window_max_ff   <= SAMPLE_MIN;
            end else begin
               sample_index_ff <= sample_index_in;
               baseline_sum_ff <= baseline_sum_in;
               window_sum_ff   <= window_sum_in;
               window_count_ff <= window_count_in;
               window_min_ff   <= window_min_in;
               window_max_ff   <= window_max_in;
            end
         end
      end
   end

   a_index_bounded: assert property (@(posedge clock) disable iff (reset)
      sample_index_ff <= INDEX_MAX)
      else $error("sample index past saturation point");

   a_event_restart: assert property (@(posedge clock) disable iff (reset)
      push |=> sample_index_ff == '0 && window_count_ff == '0)
      else $error("event state not cleared after last sample");

   a_count_le_index: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(window_count_ff) <= CMP_W'(sample_index_ff))
      else $error("window count exceeds samples seen");

endmodule

`default_nettype wire

// File: design/pci_queue.sv
// Small register queue holding finished event records between front and back.
`default_nettype none

module pci_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  full,
   output logic                  empty
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// File: design/pci_back.sv
// Back end: baseline mean by bit-serial division, correction and the result register.
`default_nettype none

module pci_back #(
   parameter int SAMPLE_BITS   = 16,
   parameter int FRACTION_BITS = 8
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        q_empty,
   input  wire logic [pci_pkg::rec_width(SAMPLE_BITS)-1:0]  q_data,
   output logic                                             q_pop,
   pci_rsp_if.source                                        rsp
);
   import pci_pkg::*;

   localparam int BS_W   = bs_width(SAMPLE_BITS);
   localparam int WS_W   = ws_width(SAMPLE_BITS);
   localparam int NW     = BS_W + FRACTION_BITS;
   localparam int DIV_W  = CFG_W + 1;
   localparam int STEP_W = $clog2(NW + 1);
   localparam int MEAN_W = SAMPLE_BITS + FRACTION_BITS + 1;
   localparam int PROD_W = CNT_W + 1 + MEAN_W;
   localparam int LVL_W  = MEAN_W + 1;
   localparam int AC_W   = ((WS_W + FRACTION_BITS > PROD_W) ? WS_W + FRACTION_BITS
                                                             : PROD_W) + 2;
   localparam int AREA_EXT_W  = (AC_W > AREA_W) ? AC_W : AREA_W;
   localparam int LEVEL_EXT_W = (LVL_W > LEVEL_W) ? LVL_W : LEVEL_W;

   localparam int O_WS  = BS_W;
   localparam int O_MIN = O_WS + WS_W;
   localparam int O_MAX = O_MIN + SAMPLE_BITS;
   localparam int O_CNT = O_MAX + SAMPLE_BITS;
   localparam int O_BL  = O_CNT + CNT_W;
   localparam int O_EMP = O_BL + CFG_W;
   localparam int O_LE  = O_EMP + 1;

   typedef enum logic [2:0] {
      B_IDLE,
      B_DIV,
      B_MEAN,
      B_PROD,
      B_OUT
   } state_type;

   state_type state_ff;

   logic [NW-1:0]                 div_q_ff;
   logic [DIV_W-1:0]              rem_ff;
   logic [DIV_W-1:0]              divisor_ff;
   logic [STEP_W-1:0]             step_ff;
   logic                          div_neg_ff;
   logic signed [WS_W-1:0]        wsum_ff;
   logic [CNT_W-1:0]              count_ff;
   logic signed [SAMPLE_BITS-1:0] min_ff;
   logic signed [SAMPLE_BITS-1:0] max_ff;
   logic                          len_err_ff;
   logic                          empty_ff;
   logic signed [MEAN_W-1:0]      mean_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [LVL_W-1:0]       lo_ff;
   logic signed [LVL_W-1:0]       hi_ff;

   logic                      rsp_valid_ff;
   logic signed [AREA_W-1:0]  area_ff;
   logic signed [LEVEL_W-1:0] min_level_ff;
   logic signed [LEVEL_W-1:0] max_level_ff;
   logic                      length_error_ff;
   logic                      window_empty_ff;

   logic signed [BS_W-1:0]     rec_bsum;
   logic signed [NW-1:0]       dividend;
   logic [NW-1:0]              dividend_mag;
   logic [DIV_W:0]             trial;
   logic                       trial_ge;
   logic [DIV_W:0]             trial_diff;
   logic signed [NW:0]         mean_full;
   logic signed [AC_W-1:0]     area_calc;
   logic signed [AREA_EXT_W-1:0]  area_ext;
   logic signed [LEVEL_EXT_W-1:0] lo_ext;
   logic signed [LEVEL_EXT_W-1:0] hi_ext;

   assign q_pop = (state_ff == B_IDLE) && !q_empty;

   always_comb begin
      rec_bsum     = q_data[BS_W-1:0];
      dividend     = NW'(rec_bsum) <<< FRACTION_BITS;
      dividend_mag = dividend[NW-1] ? NW'(-dividend) : NW'(dividend);

      // one restoring step per cycle, quotient bits shift in behind the dividend
      trial      = {rem_ff, div_q_ff[NW-1]};
      trial_ge   = trial >= {1'b0, divisor_ff};
      trial_diff = trial - {1'b0, divisor_ff};

      // floor: round a negative quotient down when there is a remainder
      mean_full = div_neg_ff ? -$signed({1'b0, div_q_ff}) - (NW+1)'(rem_ff != '0)
                             : $signed({1'b0, div_q_ff});

      area_calc = AC_W'(prod_ff) - (AC_W'(wsum_ff) <<< FRACTION_BITS);
      area_ext  = AREA_EXT_W'(area_calc);
      lo_ext    = LEVEL_EXT_W'(lo_ff);
      hi_ext    = LEVEL_EXT_W'(hi_ff);
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.area         = area_ff;
   assign rsp.min_level    = min_level_ff;
   assign rsp.max_level    = max_level_ff;
   assign rsp.length_error = length_error_ff;
   assign rsp.window_empty = window_empty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in the output step a taken result is replaced right away
         if (rsp.ready && state_ff != B_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  div_q_ff   <= dividend_mag;
                  div_neg_ff <= dividend[NW-1];
                  rem_ff     <= '0;
                  divisor_ff <= {1'b0, q_data[O_BL +: CFG_W]} + 1'b1;
                  step_ff    <= STEP_W'(NW);
                  wsum_ff    <= q_data[O_WS +: WS_W];
                  min_ff     <= q_data[O_MIN +: SAMPLE_BITS];
                  max_ff     <= q_data[O_MAX +: SAMPLE_BITS];
                  count_ff   <= q_data[O_CNT +: CNT_W];
                  empty_ff   <= q_data[O_EMP];
                  len_err_ff <= q_data[O_LE];
                  state_ff   <= B_DIV;
               end
            end
            B_DIV: begin
               div_q_ff <= {div_q_ff[NW-2:0], trial_ge};
               rem_ff   <= trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
               step_ff  <= step_ff - 1'b1;
               if (step_ff == STEP_W'(1)) begin
                  state_ff <= B_MEAN;
               end
            end
            B_MEAN: begin
               mean_ff  <= mean_full[MEAN_W-1:0];
               state_ff <= B_PROD;
            end
            B_PROD: begin
               prod_ff  <= $signed({1'b0, count_ff}) * mean_ff;
               lo_ff    <= (LVL_W'(min_ff) <<< FRACTION_BITS) - LVL_W'(mean_ff);
               hi_ff    <= (LVL_W'(max_ff) <<< FRACTION_BITS) - LVL_W'(mean_ff);
               state_ff <= B_OUT;
            end
            B_OUT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff    <= 1'b1;
                  area_ff         <= empty_ff ? '0 : area_ext[AREA_W-1:0];
                  min_level_ff    <= empty_ff ? '0 : lo_ext[LEVEL_W-1:0];
                  max_level_ff    <= empty_ff ? '0 : hi_ext[LEVEL_W-1:0];
                  length_error_ff <= len_err_ff;
                  window_empty_ff <= empty_ff;
                  state_ff        <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   a_valid_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == B_OUT))
      else $error("result raised outside output step");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && window_empty_ff |->
         area_ff == '0 && min_level_ff == '0 && max_level_ff == '0)
      else $error("empty window with nonzero levels");

   a_div_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_DIV |-> step_ff != '0)
      else $error("divider ran past its last step");

endmodule

`default_nettype wire

// File: tb/pulse_charge_integrator_tb.sv
// Self-checking testbench for the pulse charge integrator: predicted event results vs. RTL.
module pulse_charge_integrator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pci_pkg::*;

   localparam int SAMPLE_W      = 16;
   localparam int FRAC_W        = 8;
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int RANDOM_ITEMS  = 1500;

   localparam logic [CNT_W-1:0]           INDEX_SAT = 17'd131071;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_HI = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_LO = -16'sh8000;

   typedef struct {
      logic signed [AREA_W-1:0]  area;
      logic signed [LEVEL_W-1:0] min_level;
      logic signed [LEVEL_W-1:0] max_level;
      logic                      length_error;
      logic                      window_empty;
   } charge_result_type;

   logic clock;
   logic reset;

   pci_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_bus ();
   pci_rsp_if                           rsp_bus ();
   pci_csr_if                           csr_bus ();

   pulse_charge_integrator uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // register copies
   logic [EXPLEN_W-1:0] exp_length;
   logic [CFG_W-1:0]    base_last;
   logic [CFG_W-1:0]    win_first;
   logic [CFG_W-1:0]    win_last;

   // per-event accumulation
   logic [CNT_W-1:0]           pulse_index;
   logic signed [32:0]         baseline_acc;
   logic signed [32:0]         window_acc;
   logic [CNT_W-1:0]           window_hits;
   logic signed [SAMPLE_W-1:0] window_lo;
   logic signed [SAMPLE_W-1:0] window_hi;

   charge_result_type pending_charges[$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  samples_sent   = 0;
   bit  sender_gaps    = 1'b0;
   bit  sink_stalls    = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_charges.size());
         $display("status: fail");
         $finish;
      end
   end

   // result sink back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_stalls && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
      end
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   always @(posedge clock) begin
      charge_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_charges.size() == 0) begin
            report_mismatch("result transaction with nothing outstanding");
         end else begin
            want = pending_charges.pop_front();
            if (rsp_bus.area !== want.area)
               report_mismatch($sformatf("area %0d, predicted %0d", rsp_bus.area, want.area));
            if (rsp_bus.min_level !== want.min_level)
               report_mismatch($sformatf("min_level %0d, predicted %0d",
                                         rsp_bus.min_level, want.min_level));
            if (rsp_bus.max_level !== want.max_level)
               report_mismatch($sformatf("max_level %0d, predicted %0d",
                                         rsp_bus.max_level, want.max_level));
            if (rsp_bus.length_error !== want.length_error)
               report_mismatch($sformatf("length_error %b, predicted %b",
                                         rsp_bus.length_error, want.length_error));
            if (rsp_bus.window_empty !== want.window_empty)
               report_mismatch($sformatf("window_empty %b, predicted %b",
                                         rsp_bus.window_empty, want.window_empty));
         end
      end
   end

   function automatic void clear_event();
      pulse_index  = '0;
      baseline_acc = '0;
      window_acc   = '0;
      window_hits  = '0;
      window_lo    = SAMPLE_HI;
      window_hi    = SAMPLE_LO;
   endfunction

   // Accumulate one accepted sample; on the last one, queue the event result.
   function automatic void integrate_sample(input logic signed [SAMPLE_W-1:0] s, input bit last);
      charge_result_type r;
      longint            scaled, divisor, mean, area_full;
      if (pulse_index <= base_last) begin
         baseline_acc += s;
      end else if (pulse_index >= win_first && pulse_index <= win_last
                   && pulse_index < INDEX_SAT) begin
         window_acc += s;
         window_hits++;
         if (s < window_lo) window_lo = s;
         if (s > window_hi) window_hi = s;
      end
      if (pulse_index != INDEX_SAT) pulse_index++;
      if (!last) return;
      r.window_empty = (window_hits == 0);
      r.length_error = (pulse_index != exp_length);
      if (r.window_empty) begin
         r.area      = '0;
         r.min_level = '0;
         r.max_level = '0;
      end else begin
         scaled  = longint'(baseline_acc) * (64'sd1 <<< FRAC_W);
         divisor = longint'(base_last) + 1;
         mean    = scaled / divisor;
         // floor, not truncation
         if (scaled % divisor != 0 && scaled < 0) mean -= 1;
         area_full   = -(longint'(window_acc) * (64'sd1 <<< FRAC_W)
                         - longint'(window_hits) * mean);
         r.area      = AREA_W'(area_full);
         r.min_level = LEVEL_W'(longint'(window_lo) * (64'sd1 <<< FRAC_W) - mean);
         r.max_level = LEVEL_W'(longint'(window_hi) * (64'sd1 <<< FRAC_W) - mean);
      end
      pending_charges.insert(pending_charges.size(), r);
      clear_event();
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit last);
      @(negedge clock);
      if (sender_gaps && $urandom_range(0, 7) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.sample      = s;
      req_bus.last_sample = last;
      do @(posedge clock); while (!req_bus.ready);
      integrate_sample(s, last);
      samples_sent++;
   endtask

   task automatic hold_until_drained(input int extra_cycles);
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_charges.size() != 0) @(posedge clock);
      repeat (extra_cycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] which, input logic [EXPLEN_W-1:0] value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = which;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
      case (which)
         CSR_EXPECTED_LENGTH: exp_length = value;
         CSR_BASELINE_LAST:   base_last  = value[CFG_W-1:0];
         CSR_WINDOW_START:    win_first  = value[CFG_W-1:0];
         default:             win_last   = value[CFG_W-1:0];
      endcase
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // only called with the block idle
   task automatic configure(input int len, input int bl, input int ws, input int we);
      hold_until_drained(SETTLE_CYCLES);
      write_csr(CSR_EXPECTED_LENGTH, EXPLEN_W'(len));
      write_csr(CSR_BASELINE_LAST, EXPLEN_W'(bl));
      write_csr(CSR_WINDOW_START, EXPLEN_W'(ws));
      write_csr(CSR_WINDOW_END, EXPLEN_W'(we));
   endtask

   function automatic logic signed [SAMPLE_W-1:0] draw_sample();
      case ($urandom_range(0, 7))
         0:       return SAMPLE_LO;
         1:       return SAMPLE_HI;
         2, 3, 4: return SAMPLE_W'($urandom);
         default: return SAMPLE_W'($urandom_range(0, 400)) - 16'sd200;
      endcase
   endfunction

   task automatic send_event(input int n);
      for (int i = 0; i < n; i++)
         send_sample(draw_sample(), i == n - 1);
   endtask

   // register defaults straight out of reset; event ends inside the default baseline
   task automatic test_reset_defaults();
      sender_gaps = 1'b1;
      sink_stalls = 1'b1;
      send_event(24);
   endtask

   task automatic test_special_cases();
      configure(8, 2, 4, 6);
      send_sample(16'sd0, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(SAMPLE_HI, 1'b0);
      send_sample(SAMPLE_LO, 1'b0);
      send_sample(SAMPLE_HI, 1'b0);
      send_sample(SAMPLE_LO, 1'b0);
      send_sample(16'sd100, 1'b0);
      send_sample(16'sd5, 1'b1);
      send_event(3);                 // too short
      configure(6, 3, 1, 5);         // window overlaps baseline
      send_event(6);
      configure(2, 0, 6, 1);         // window start after end
      send_event(2);
      send_event(1);                 // single-sample event
      configure(2, 65535, 1, 3);     // event ends inside baseline
      send_event(3);
   endtask

   task automatic test_long_events();
      sender_gaps = 1'b0;
      sink_stalls = 1'b0;
      // long baseline at the negative rail, window at the positive rail
      configure(300, 254, 255, 299);
      for (int i = 0; i < 255; i++) send_sample(SAMPLE_LO, 1'b0);
      for (int i = 255; i < 300; i++) send_sample(SAMPLE_HI, i == 299);
      // largest baseline and window register values
      configure(65536, 65535, 65535, 65535);
      send_event(40);
   endtask

   task automatic test_random_events();
      int start_count, len, bl, ws, we, phase_end, n;
      start_count = samples_sent;
      while (samples_sent - start_count < RANDOM_ITEMS) begin
         len = $urandom_range(2, 40);
         bl  = $urandom_range(0, 12);
         ws  = $urandom_range(1, 40);
         we  = $urandom_range(ws, 48);
         if ($urandom_range(0, 7) == 0) we = $urandom_range(1, ws);
         if ($urandom_range(0, 15) == 0) len = 65536;
         if ($urandom_range(0, 15) == 0) bl = 65535;
         if ($urandom_range(0, 15) == 0) we = 65535;
         if ($urandom_range(0, 15) == 0) ws = 65535;
         configure(len, bl, ws, we);
         // quiet handshakes for the last quarter of the run
         if (samples_sent - start_count > RANDOM_ITEMS * 3 / 4) begin
            sender_gaps = 1'b0;
            sink_stalls = 1'b0;
         end else begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
         end
         phase_end = samples_sent + $urandom_range(60, 160);
         while (samples_sent < phase_end) begin
            if (exp_length <= 48 && $urandom_range(0, 4) != 0)
               n = exp_length;
            else
               n = $urandom_range(1, 48);
            send_event(n);
            if ($urandom_range(0, 19) == 0) hold_until_drained(0);
         end
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.sample      = '0;
      req_bus.last_sample = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = CSR_EXPECTED_LENGTH;
      csr_bus.data        = '0;
      exp_length          = EXPECTED_LENGTH_RST;
      base_last           = BASELINE_LAST_RST;
      win_first           = WINDOW_START_RST;
      win_last            = WINDOW_END_RST;
      clear_event();
      repeat (2) @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_special_cases();
      test_long_events();
      test_random_events();

      hold_until_drained(SETTLE_CYCLES);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: pulse_charge_integrator.f
design/pci_pkg.sv
design/pci_if.sv
design/pci_front.sv
design/pci_queue.sv
design/pci_back.sv
design/pulse_charge_integrator.sv
tb/pulse_charge_integrator_tb.sv
